/* hdl/lighting_effect_frame_generator_macros.svh */
// Assertion macros for the lighting effect frame generator.
`ifndef LIGHTING_EFFECT_FRAME_GENERATOR_MACROS_SVH
`define LIGHTING_EFFECT_FRAME_GENERATOR_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside reset.
`define LEFG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lefg assertion failed");

// Next-cycle implication, checked outside reset.
`define LEFG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lefg assertion failed");

`else

`define LEFG_ASSERT_NOW(label, ante, cons)
`define LEFG_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* hdl/lefg_pkg.sv */
// Shared types and constants for the lighting effect frame generator.
`timescale 1ns / 1ps

package lefg_pkg;

    localparam int PHASE_BITS = 24;
    // operand width of the shared multiplier: wide enough for a rate or a phase offset
    localparam int MUL_W      = (PHASE_BITS > 16) ? PHASE_BITS : 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] MODE_RGB     = 2'd0;
    localparam logic [1:0] MODE_PANTILT = 2'd1;
    localparam logic [1:0] MODE_AUTO    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_RED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_GREEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_BLUE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PAN_HIGH   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_LOW   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_HIGH  = 3'd7;

    localparam logic [7:0] STROBE_ON = 8'd6;

    typedef struct packed {
        logic [7:0] knob_zero;
        logic [7:0] knob_one;
        logic [7:0] knob_two;
        logic [7:0] knob_three;
        logic [7:0] knob_four;
    } knob_word_t;

    typedef struct packed {
        logic [7:0] red_level;
        logic [7:0] green_level;
        logic [7:0] blue_level;
        logic [7:0] pan_value;
        logic [7:0] tilt_value;
        logic [7:0] color_value;
        logic [7:0] strobe_value;
        logic [7:0] dimmer_value;
        logic [7:0] gobo_value;
    } frame_word_t;

endpackage

/* hdl/lighting_effect_frame_generator.sv */
// Lighting effect frame generator: channel bank, phase sequencer and shared multiplier.
`timescale 1ns / 1ps
`include "lighting_effect_frame_generator_macros.svh"

// Takes one frame tick word of five knob bytes and returns one word with all
// nine channel bytes. In the manual modes an accepted tick goes straight to the
// push step, which loads its word into the output register. In auto mode
// one multiplier is stepped through the red, green and blue channels, each
// through rate times speed, phase add, square and scale, before the push step
// loads the word into the output register. The input is stalled until the
// push step is done; the output register lets a new tick be accepted while a
// finished word still waits downstream, and the push step holds the next word
// until it frees.
module lighting_effect_frame_generator (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  lefg_pkg::knob_word_t                   in_data,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output lefg_pkg::frame_word_t                  out_data,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [lefg_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [lefg_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import lefg_pkg::*;

    localparam int PB = PHASE_BITS;
    localparam logic [PB-1:0] PHASE_RESET = {2'b11, {(PB-2){1'b0}}};
    localparam logic [PB+1:0] FULL_ONE    = {2'b01, {PB{1'b0}}};
    localparam logic [PB+1:0] FULL_THREE  = {2'b11, {PB{1'b0}}};

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_RATE,
        ST_ADD_PHASE,
        ST_MUL_SQ,
        ST_WAVE,
        ST_PUSH
    } state_t;

    state_t              state_reg;
    logic [1:0]          ch_reg;
    logic [7:0]          speed_reg;

    logic [1:0]          mode_reg;
    logic [15:0]         rate_red_reg;
    logic [15:0]         rate_green_reg;
    logic [15:0]         rate_blue_reg;
    logic [7:0]          pan_low_reg;
    logic [7:0]          pan_high_reg;
    logic [7:0]          tilt_low_reg;
    logic [7:0]          tilt_high_reg;

    logic [PB-1:0]       phase_reg [3];
    logic [7:0]          pan_pos_reg;
    logic                pan_up_reg;
    logic [7:0]          tilt_pos_reg;
    logic                tilt_up_reg;
    logic [7:0]          bank_reg [9];

    logic [2*MUL_W-1:0]  prod_reg;
    logic [PB:0]         u_reg;
    logic                first_reg;

    logic                out_valid_reg;
    frame_word_t         out_data_reg;

    logic                in_accept;
    logic                out_free;
    logic [15:0]         rate_sel;
    logic [PB-1:0]       phase_new;
    logic [PB+1:0]       q_w;
    logic [PB+1:0]       c_w;
    logic [PB+1:0]       diff_w;
    logic [MUL_W-1:0]    mul_a;
    logic [MUL_W-1:0]    mul_b;
    logic [2*PB-1:0]     sq_w;
    logic [2*PB+7:0]     scaled_w;
    logic [6:0]          fl_w;
    logic                exact_w;
    logic [7:0]          wave_w;
    logic                pan_up_next;
    logic [7:0]          pan_pos_next;
    logic                tilt_up_next;
    logic [7:0]          tilt_pos_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        case (ch_reg)
            CH_RED:   rate_sel = rate_red_reg;
            CH_GREEN: rate_sel = rate_green_reg;
            default:  rate_sel = rate_blue_reg;
        endcase
    end

    // shared multiplier: rate times speed, then the phase offset squared
    always_comb
    begin
        if (state_reg == ST_MUL_SQ)
        begin
            mul_a = MUL_W'(u_reg[PB-1:0]);
            mul_b = MUL_W'(u_reg[PB-1:0]);
        end
        else
        begin
            mul_a = MUL_W'(rate_sel);
            mul_b = MUL_W'(speed_reg);
        end
    end

    // offset of 4*phase from the parabola center, at most FULL_ONE
    assign phase_new = phase_reg[ch_reg] + prod_reg[PB-1:0];
    assign q_w       = {phase_new, 2'b00};
    assign c_w       = phase_new[PB-1] ? FULL_THREE : FULL_ONE;
    assign diff_w    = (q_w >= c_w) ? (q_w - c_w) : (c_w - q_w);

    // 255 * u^2 / 2^(2PB+1), floored, with an exactness flag for the upper half
    assign sq_w      = prod_reg[2*PB-1:0];
    assign scaled_w  = {sq_w, 8'd0} - {8'd0, sq_w};
    assign fl_w      = scaled_w[2*PB+7:2*PB+1];
    assign exact_w   = (scaled_w[2*PB:0] == '0);

    always_comb
    begin
        if (u_reg[PB])
            wave_w = 8'd127;
        else if (first_reg)
            wave_w = 8'd255 - {1'b0, fl_w} - {7'd0, !exact_w};
        else
            wave_w = {1'b0, fl_w};
    end

    // bounce: the low test wins when both bounds are crossed
    always_comb
    begin
        pan_up_next = pan_up_reg;
        if (pan_pos_reg > pan_high_reg)
            pan_up_next = 1'b0;
        if (pan_pos_reg < pan_low_reg)
            pan_up_next = 1'b1;
        pan_pos_next = pan_up_next ? pan_pos_reg + 8'd1 : pan_pos_reg - 8'd1;

        tilt_up_next = tilt_up_reg;
        if (tilt_pos_reg > tilt_high_reg)
            tilt_up_next = 1'b0;
        if (tilt_pos_reg < tilt_low_reg)
            tilt_up_next = 1'b1;
        tilt_pos_next = tilt_up_next ? tilt_pos_reg + 8'd1 : tilt_pos_reg - 8'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_AUTO;
            rate_red_reg   <= 16'd3355;
            rate_green_reg <= 16'd8389;
            rate_blue_reg  <= 16'd16777;
            pan_low_reg    <= 8'd125;
            pan_high_reg   <= 8'd140;
            tilt_low_reg   <= 8'd30;
            tilt_high_reg  <= 8'd55;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MODE:       mode_reg       <= cfg_data[1:0];
                CFG_RATE_RED:   rate_red_reg   <= cfg_data;
                CFG_RATE_GREEN: rate_green_reg <= cfg_data;
                CFG_RATE_BLUE:  rate_blue_reg  <= cfg_data;
                CFG_PAN_LOW:    pan_low_reg    <= cfg_data[7:0];
                CFG_PAN_HIGH:   pan_high_reg   <= cfg_data[7:0];
                CFG_TILT_LOW:   tilt_low_reg   <= cfg_data[7:0];
                CFG_TILT_HIGH:  tilt_high_reg  <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= CH_RED;
            speed_reg     <= 8'd0;
            prod_reg      <= '0;
            u_reg         <= '0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            pan_pos_reg   <= 8'd132;
            pan_up_reg    <= 1'b1;
            tilt_pos_reg  <= 8'd30;
            tilt_up_reg   <= 1'b1;
            for (int i = 0; i < 3; i++)
                phase_reg[i] <= PHASE_RESET;
            for (int i = 0; i < 9; i++)
                bank_reg[i] <= 8'd0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != ST_PUSH))
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        speed_reg <= in_data.knob_zero;
                        ch_reg    <= CH_RED;
                        state_reg <= (mode_reg == MODE_AUTO) ? ST_MUL_RATE : ST_PUSH;
                        case (mode_reg)
                            MODE_RGB:
                            begin
                                bank_reg[0] <= in_data.knob_zero;
                                bank_reg[1] <= in_data.knob_one;
                                bank_reg[2] <= in_data.knob_two;
                            end
                            MODE_PANTILT:
                            begin
                                bank_reg[3] <= in_data.knob_zero;
                                bank_reg[4] <= in_data.knob_one;
                                bank_reg[5] <= in_data.knob_two;
                                bank_reg[6] <= STROBE_ON;
                                bank_reg[7] <= in_data.knob_three;
                                bank_reg[8] <= in_data.knob_four;
                            end
                            MODE_AUTO:
                            begin
                                pan_pos_reg  <= pan_pos_next;
                                pan_up_reg   <= pan_up_next;
                                tilt_pos_reg <= tilt_pos_next;
                                tilt_up_reg  <= tilt_up_next;
                                bank_reg[3]  <= pan_pos_next;
                                bank_reg[4]  <= tilt_pos_next;
                                bank_reg[5]  <= in_data.knob_two;
                                bank_reg[6]  <= STROBE_ON;
                                bank_reg[7]  <= in_data.knob_three;
                                bank_reg[8]  <= in_data.knob_four;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MUL_RATE:
                begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= ST_ADD_PHASE;
                end
                ST_ADD_PHASE:
                begin
                    phase_reg[ch_reg] <= phase_new;
                    u_reg             <= diff_w[PB:0];
                    first_reg         <= !phase_new[PB-1];
                    state_reg         <= ST_MUL_SQ;
                end
                ST_MUL_SQ:
                begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= ST_WAVE;
                end
                ST_WAVE:
                begin
                    case (ch_reg)
                        CH_RED:   bank_reg[0] <= wave_w;
                        CH_GREEN: bank_reg[1] <= wave_w;
                        default:  bank_reg[2] <= wave_w;
                    endcase
                    if (ch_reg == CH_BLUE)
                        state_reg <= ST_PUSH;
                    else
                    begin
                        ch_reg    <= ch_reg + 2'd1;
                        state_reg <= ST_MUL_RATE;
                    end
                end
                ST_PUSH:
                begin
                    if (out_free)
                    begin
                        out_data_reg.red_level    <= bank_reg[0];
                        out_data_reg.green_level  <= bank_reg[1];
                        out_data_reg.blue_level   <= bank_reg[2];
                        out_data_reg.pan_value    <= bank_reg[3];
                        out_data_reg.tilt_value   <= bank_reg[4];
                        out_data_reg.color_value  <= bank_reg[5];
                        out_data_reg.strobe_value <= bank_reg[6];
                        out_data_reg.dimmer_value <= bank_reg[7];
                        out_data_reg.gobo_value   <= bank_reg[8];
                        out_valid_reg             <= 1'b1;
                        state_reg                 <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `LEFG_ASSERT_NEXT(a_auto_starts_red, in_accept && (mode_reg == MODE_AUTO),
        (state_reg == ST_MUL_RATE) && (ch_reg == CH_RED))
    `LEFG_ASSERT_NEXT(a_manual_to_push, in_accept && (mode_reg != MODE_AUTO),
        state_reg == ST_PUSH)
    `LEFG_ASSERT_NEXT(a_blue_ends_walk, (state_reg == ST_WAVE) && (ch_reg == CH_BLUE),
        state_reg == ST_PUSH)
    `LEFG_ASSERT_NOW(a_word_from_push, $rose(out_valid_reg), $past(state_reg) == ST_PUSH)
    `LEFG_ASSERT_NOW(a_strobe_codes, out_valid_reg,
        (out_data_reg.strobe_value == 8'd0) || (out_data_reg.strobe_value == STROBE_ON))

endmodule
